### hw/rtl/tlas_pkg.sv
// ----------------------------------------------------------------------------
// Two-line assembly schedule package
// Shared field widths, register indexes and the payload structs of the
// station and result channels.
// ----------------------------------------------------------------------------
package tlas_pkg;

  localparam int unsigned WORK_W = 16;
  localparam int unsigned COST_W = 24;
  localparam int unsigned STATION_NUM_W = 7;
  localparam int unsigned LINE_W = 2;
  localparam int unsigned CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ENTRY_ONE = 2'd0,
    CFG_ENTRY_TWO = 2'd1,
    CFG_EXIT_ONE  = 2'd2,
    CFG_EXIT_TWO  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [WORK_W-1:0] work_cost_one;
    logic [WORK_W-1:0] work_cost_two;
    logic [WORK_W-1:0] move_into_one;
    logic [WORK_W-1:0] move_into_two;
    logic              final_station;
  } station_t;

  typedef struct packed {
    logic [STATION_NUM_W-1:0] station_number;
    logic [LINE_W-1:0]        chosen_line;
    logic [COST_W-1:0]        total_cost;
    logic                     overflow_flag;
    logic                     last_result;
  } result_t;

endpackage

### hw/rtl/tlas_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tlas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/two_line_assembly_schedule.sv
// ----------------------------------------------------------------------------
// Two-line assembly schedule
// Dynamic programming over two assembly lines, one station per item, with a
// traceback and in-order emission of the chosen line on the final station.
//
//   Channel   Signals                              Transfer
//   station   start, busy, station                 start && !busy
//   result    result_strobe, result                result_strobe
//   config    cfg_valid, cfg_ready, cfg_index,     cfg_valid && cfg_ready
//             cfg_data
//
// A stored station has its line-one minimum formed by the shared
// add-and-compare unit in the accept cycle and its line-two minimum in
// the next. A station beyond capacity is not stored and sets the overflow
// flag. A final station is followed by an exit step, a traceback through
// the choice RAM read port, a RAM read step and one result per stored station.
// Reset is synchronous and clears the control state and the configuration.
// The receiver cannot stall; results leave at one per cycle.
// ----------------------------------------------------------------------------
module two_line_assembly_schedule #(
  parameter int unsigned MAX_STATIONS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  tlas_pkg::station_t                   station,
  output logic                                 result_strobe,
  output tlas_pkg::result_t                    result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  tlas_pkg::cfg_reg_t                   cfg_index,
  input  logic [tlas_pkg::WORK_W-1:0]          cfg_data
);

  localparam int unsigned ADDR_W = $clog2(MAX_STATIONS);
  localparam int unsigned CNT_W  = $clog2(MAX_STATIONS + 1);
  localparam int unsigned COST_W = tlas_pkg::COST_W;
  localparam int unsigned WORK_W = tlas_pkg::WORK_W;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_LINE2   = 6'b000010,
    ST_EXIT    = 6'b000100,
    ST_TRACE   = 6'b001000,
    ST_EMIT_RD = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [WORK_W-1:0] entry_one, entry_two, exit_one, exit_two;
  logic [COST_W-1:0] best_one, best_two, hold_one, total;
  logic [WORK_W-1:0] hold_work_two, hold_move_two;
  logic              hold_final, hold_bit0, cur_line, dropped;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] trace_k, emit_j;

  logic [COST_W-1:0] base_a, base_b, sum_a, sum_b, unit_min;
  logic [WORK_W-1:0] add_common, add_a, add_b;
  logic              unit_sel_b, first, accept, room, prev_line, emit_last;

  logic              choice_wr_en, answer_wr_en, answer_wr_data, answer_rd_data;
  logic [ADDR_W-1:0] choice_wr_addr, choice_rd_addr, answer_wr_addr, answer_rd_addr;
  logic [1:0]        choice_rd_data;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign first     = (count == '0);
  assign room      = (count < CNT_W'(MAX_STATIONS));
  assign prev_line = cur_line ? choice_rd_data[1] : choice_rd_data[0];
  assign emit_last = ((CNT_W'(emit_j) + CNT_W'(1)) == count);

  // Shared add-and-compare unit; side a is the path from line one.
  always_comb begin
    base_a     = best_one;
    base_b     = best_two;
    add_common = '0;
    add_a      = '0;
    add_b      = '0;
    case (state)
      ST_IDLE: begin
        base_a     = first ? COST_W'(entry_one) : best_one;
        base_b     = first ? COST_W'(entry_one) : best_two;
        add_common = station.work_cost_one;
        add_b      = first ? '0 : station.move_into_one;
      end
      ST_LINE2: begin
        base_a     = first ? COST_W'(entry_two) : best_one;
        base_b     = first ? COST_W'(entry_two) : best_two;
        add_common = hold_work_two;
        add_a      = first ? '0 : hold_move_two;
      end
      ST_EXIT: begin
        add_a = exit_one;
        add_b = exit_two;
      end
      default: begin
      end
    endcase
    sum_a      = base_a + COST_W'(add_common) + COST_W'(add_a);
    sum_b      = base_b + COST_W'(add_common) + COST_W'(add_b);
    unit_sel_b = (sum_b < sum_a);
    unit_min   = unit_sel_b ? sum_b : sum_a;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (room) begin
            state_next = ST_LINE2;
          end else if (station.final_station) begin
            state_next = ST_EXIT;
          end
        end
      end
      ST_LINE2:   state_next = hold_final ? ST_EXIT : ST_IDLE;
      ST_EXIT:    state_next = (count == CNT_W'(1)) ? ST_EMIT_RD : ST_TRACE;
      ST_TRACE:   state_next = (trace_k == ADDR_W'(1)) ? ST_EMIT_RD : ST_TRACE;
      ST_EMIT_RD: state_next = ST_EMIT;
      ST_EMIT:    state_next = emit_last ? ST_IDLE : ST_EMIT;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    choice_wr_en   = (state == ST_LINE2);
    choice_wr_addr = count[ADDR_W-1:0];
    choice_rd_addr = trace_k - ADDR_W'(1);
    if (state == ST_EXIT) begin
      choice_rd_addr = ADDR_W'(count - CNT_W'(1));
    end
    answer_wr_en   = (state == ST_EXIT) || (state == ST_TRACE);
    answer_wr_addr = trace_k - ADDR_W'(1);
    answer_wr_data = prev_line;
    if (state == ST_EXIT) begin
      answer_wr_addr = ADDR_W'(count - CNT_W'(1));
      answer_wr_data = unit_sel_b;
    end
    answer_rd_addr = (state == ST_EMIT) ? emit_j + ADDR_W'(1) : '0;
  end

  tlas_ram #(
    .WIDTH(2),
    .DEPTH(MAX_STATIONS)
  ) u_choice_ram (
    .clk     (clk),
    .wr_en   (choice_wr_en),
    .wr_addr (choice_wr_addr),
    .wr_data ({unit_sel_b, hold_bit0}),
    .rd_addr (choice_rd_addr),
    .rd_data (choice_rd_data)
  );

  tlas_ram #(
    .WIDTH(1),
    .DEPTH(MAX_STATIONS)
  ) u_answer_ram (
    .clk     (clk),
    .wr_en   (answer_wr_en),
    .wr_addr (answer_wr_addr),
    .wr_data (answer_wr_data),
    .rd_addr (answer_rd_addr),
    .rd_data (answer_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_one <= '0;
      entry_two <= '0;
      exit_one  <= '0;
      exit_two  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tlas_pkg::CFG_ENTRY_ONE: entry_one <= cfg_data;
        tlas_pkg::CFG_ENTRY_TWO: entry_two <= cfg_data;
        tlas_pkg::CFG_EXIT_ONE:  exit_one  <= cfg_data;
        tlas_pkg::CFG_EXIT_TWO:  exit_two  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      best_one      <= '0;
      best_two      <= '0;
      count         <= '0;
      dropped       <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            hold_final    <= station.final_station;
            hold_work_two <= station.work_cost_two;
            hold_move_two <= station.move_into_two;
            hold_one      <= unit_min;
            hold_bit0     <= unit_sel_b;
            if (!room) begin
              dropped <= 1'b1;
            end
          end
        end
        ST_LINE2: begin
          best_one <= hold_one;
          best_two <= unit_min;
          count    <= count + CNT_W'(1);
        end
        ST_EXIT: begin
          total    <= unit_min;
          cur_line <= unit_sel_b;
          trace_k  <= ADDR_W'(count - CNT_W'(1));
        end
        ST_TRACE: begin
          cur_line <= prev_line;
          trace_k  <= trace_k - ADDR_W'(1);
        end
        ST_EMIT_RD: begin
          emit_j <= '0;
        end
        ST_EMIT: begin
          result_strobe         <= 1'b1;
          result.station_number <= tlas_pkg::STATION_NUM_W'(emit_j) +
                                   tlas_pkg::STATION_NUM_W'(1);
          result.chosen_line    <= {1'b0, answer_rd_data} + 2'd1;
          result.total_cost     <= total;
          result.overflow_flag  <= dropped;
          result.last_result    <= emit_last;
          emit_j                <= emit_j + ADDR_W'(1);
          if (emit_last) begin
            best_one <= '0;
            best_two <= '0;
            count    <= '0;
            dropped  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(state == ST_EMIT))
    else $error("result strobe without an emission cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_STATIONS))
    else $error("station count beyond capacity");

  a_stored_station_line2: assert property (@(posedge clk) disable iff (rst)
    (accept && room) |=> (state == ST_LINE2))
    else $error("stored station did not enter the line-two step");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last_result) |=> !result_strobe)
    else $error("result after the last result of a problem");

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Two-line assembly schedule testbench
// Drives station items through the start/busy handshake and loads the entry
// and exit costs over the config channel while the block is idle. A
// scoreboard class keeps its own forward minima, choice bits and traceback,
// and compares every strobed result with the oldest predicted one. The run
// goes through directed problems, then random problems under three sender
// idle rates with several cost settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned WORK_W = tlas_pkg::WORK_W;
  localparam int unsigned COST_W = tlas_pkg::COST_W;
  localparam int unsigned STATION_NUM_W = tlas_pkg::STATION_NUM_W;

  class schedule_board;
    logic [WORK_W-1:0] entry_one, entry_two, exit_one, exit_two;
    int unsigned best_one, best_two;
    logic [1:0] choices [CAPACITY];
    logic lines [CAPACITY];
    int stored;
    logic dropped;
    tlas_pkg::result_t pending_results [$];
    int unsigned mismatch_count;

    function new();
      entry_one = '0;
      entry_two = '0;
      exit_one = '0;
      exit_two = '0;
      mismatch_count = 0;
      clear_problem();
    endfunction

    function void clear_problem();
      best_one = 0;
      best_two = 0;
      stored = 0;
      dropped = 1'b0;
      foreach (choices[i]) begin
        choices[i] = 2'b00;
        lines[i] = 1'b0;
      end
    endfunction

    function void set_reg(tlas_pkg::cfg_reg_t idx, logic [WORK_W-1:0] val);
      case (idx)
        tlas_pkg::CFG_ENTRY_ONE: entry_one = val;
        tlas_pkg::CFG_ENTRY_TWO: entry_two = val;
        tlas_pkg::CFG_EXIT_ONE:  exit_one = val;
        tlas_pkg::CFG_EXIT_TWO:  exit_two = val;
        default: ;
      endcase
    endfunction

    function void add_station(tlas_pkg::station_t s);
      int unsigned stay_one, cross_one, cross_two, stay_two, t_one, t_two, total;
      logic [1:0] pick;
      logic win;
      int k;
      tlas_pkg::result_t r;
      if (stored < CAPACITY) begin
        if (stored == 0) begin
          best_one = entry_one + s.work_cost_one;
          best_two = entry_two + s.work_cost_two;
          choices[0] = 2'b00;
        end else begin
          stay_one = best_one + s.work_cost_one;
          cross_one = best_two + s.work_cost_one + s.move_into_one;
          cross_two = best_one + s.work_cost_two + s.move_into_two;
          stay_two = best_two + s.work_cost_two;
          pick = 2'b00;
          if (stay_one <= cross_one) begin
            best_one = stay_one;
          end else begin
            best_one = cross_one;
            pick[0] = 1'b1;
          end
          if (cross_two <= stay_two) begin
            best_two = cross_two;
          end else begin
            best_two = stay_two;
            pick[1] = 1'b1;
          end
          choices[stored] = pick;
        end
        stored++;
      end else begin
        dropped = 1'b1;
      end
      if (!s.final_station) return;
      t_one = best_one + exit_one;
      t_two = best_two + exit_two;
      if (t_one <= t_two) begin
        total = t_one;
        win = 1'b0;
      end else begin
        total = t_two;
        win = 1'b1;
      end
      lines[stored-1] = win;
      for (k = stored - 1; k > 0; k--) begin
        lines[k-1] = lines[k] ? choices[k][1] : choices[k][0];
      end
      for (k = 0; k < stored; k++) begin
        r.station_number = STATION_NUM_W'(k + 1);
        r.chosen_line = {1'b0, lines[k]} + 2'd1;
        r.total_cost = total[COST_W-1:0];
        r.overflow_flag = dropped;
        r.last_result = (k + 1 == stored);
        pending_results.push_back(r);
      end
      clear_problem();
    endfunction

    function void check_result(tlas_pkg::result_t got);
      tlas_pkg::result_t want;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: stn %0d line %0d cost %0d ovf %0b last %0b",
                   got.station_number, got.chosen_line, got.total_cost,
                   got.overflow_flag, got.last_result);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: want %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                   want.station_number, want.chosen_line, want.total_cost,
                   want.overflow_flag, want.last_result,
                   got.station_number, got.chosen_line, got.total_cost,
                   got.overflow_flag, got.last_result);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  tlas_pkg::station_t station;
  logic result_strobe;
  tlas_pkg::result_t result;
  logic cfg_valid;
  logic cfg_ready;
  tlas_pkg::cfg_reg_t cfg_index;
  logic [WORK_W-1:0] cfg_data;

  schedule_board board;
  int unsigned idle_pct;
  int unsigned quiet_cycles;

  two_line_assembly_schedule #(
    .MAX_STATIONS(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .station(station),
    .result_strobe(result_strobe),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe) board.check_result(result);
      if (start && !busy) board.add_station(station);
      if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  function automatic logic [WORK_W-1:0] random_cost();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return WORK_W'($urandom_range(0, 16'hFFFF));
    else if (pick < 8) return WORK_W'($urandom_range(0, 3));
    else if (pick == 8) return 16'hFFFF;
    else return 16'h0000;
  endfunction

  function automatic tlas_pkg::station_t make_station(logic [WORK_W-1:0] w1,
                                                      logic [WORK_W-1:0] w2,
                                                      logic [WORK_W-1:0] m1,
                                                      logic [WORK_W-1:0] m2,
                                                      logic fin);
    tlas_pkg::station_t s;
    s.work_cost_one = w1;
    s.work_cost_two = w2;
    s.move_into_one = m1;
    s.move_into_two = m2;
    s.final_station = fin;
    return s;
  endfunction

  function automatic int random_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return $urandom_range(1, 6);
    else if (pick < 95) return $urandom_range(7, 24);
    else return $urandom_range(25, CAPACITY);
  endfunction

  task automatic send_station(input tlas_pkg::station_t s);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    station <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_problem(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      send_station(make_station(random_cost(), random_cost(), random_cost(), random_cost(),
                                i == len - 1));
    end
  endtask

  task automatic drain(input int settle);
    start <= 1'b0;
    @(negedge clk);
    while (board.pending_results.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input tlas_pkg::cfg_reg_t idx, input logic [WORK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_costs(input logic [WORK_W-1:0] e1, input logic [WORK_W-1:0] e2,
                            input logic [WORK_W-1:0] x1, input logic [WORK_W-1:0] x2);
    write_reg(tlas_pkg::CFG_ENTRY_ONE, e1);
    write_reg(tlas_pkg::CFG_ENTRY_TWO, e2);
    write_reg(tlas_pkg::CFG_EXIT_ONE, x1);
    write_reg(tlas_pkg::CFG_EXIT_TWO, x2);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase;
    int sent;
    int len;
    int long_len [3];
    board = new();
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    station = '0;
    cfg_valid = 1'b0;
    cfg_index = tlas_pkg::CFG_ENTRY_ONE;
    cfg_data = '0;
    idle_pct = 0;
    long_len = '{65, 64, 68};
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed problems with the reset costs, then with every entry and exit cost at its maximum.
    send_station(make_station(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_station(make_station(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_station(make_station(16'd10, 16'd5, 16'hFFFF, 16'hFFFF, 1'b1));
    send_station(make_station(16'd1, 16'd100, 16'd0, 16'd0, 1'b0));
    send_station(make_station(16'd100, 16'd1, 16'd0, 16'd2, 1'b0));
    send_station(make_station(16'd1, 16'd100, 16'd3, 16'd0, 1'b1));
    send_station(make_station(16'd5, 16'd5, 16'd7, 16'd7, 1'b0));
    send_station(make_station(16'd5, 16'd5, 16'd0, 16'd0, 1'b1));
    send_station(make_station(16'd40, 16'd2, 16'd9, 16'd9, 1'b0));
    send_station(make_station(16'd40, 16'd2, 16'd1, 16'd50, 1'b1));
    send_station(make_station(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    send_station(make_station(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    send_station(make_station(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    drain(8);
    load_costs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_station(make_station(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_station(make_station(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b0));
    send_station(make_station(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1));
    send_station(make_station(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    send_station(make_station(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    drain(8);

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 27 : (phase == 1) ? 63 : 0;
      if (phase == 1) load_costs(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
      else load_costs(random_cost(), random_cost(), random_cost(), random_cost());
      run_problem(long_len[phase]);
      sent = long_len[phase];
      while (sent < 120) begin
        len = random_length();
        run_problem(len);
        sent += len;
        if ($urandom_range(0, 5) == 0) drain(0);
        if (sent >= 60 && sent - len < 60) begin
          drain(8);
          load_costs(random_cost(), random_cost(), random_cost(), random_cost());
        end
      end
      drain(8);
    end

    drain(20);
    if (board.mismatch_count == 0 && board.pending_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/tlas_pkg.sv
hw/rtl/tlas_ram.sv
hw/rtl/two_line_assembly_schedule.sv
tb/sv/tb_top.sv
